// ----- design/olm_pkg.sv -----
// Shared constants, codes and types for the ordered list move unit.
`timescale 1ns / 1ps

package olm_pkg;

  // List size and field widths
  localparam int MAX_ENTRIES = 64;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int FIELD_W     = 7;

  // entry_count after reset
  localparam logic [FIELD_W-1:0] COUNT_RESET = FIELD_W'(MAX_ENTRIES);

  typedef enum logic {
    OP_MOVE = 1'b0,
    OP_READ = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_CLAMP = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOKUP,
    S_FETCH,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_PLACE,
    S_OUT
  } state_t;

  // One table request per cycle: one write, one registered read
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [IDX_W-1:0] wdata;
    logic [IDX_W-1:0] raddr;
  } tbl_req_t;

  // Finished result, as it goes to the output register
  typedef struct packed {
    logic [FIELD_W-1:0] entry;
    logic [FIELD_W-1:0] slot;
    status_t            status;
  } res_t;

endpackage

// ----- design/olm_cmd_if.sv -----
// Command channel: move or read requests.
`timescale 1ns / 1ps

interface olm_cmd_if;
  logic                              valid;
  logic                              ready;
  logic                              opcode;
  logic [olm_pkg::FIELD_W-1:0]       entry_number;
  logic signed [olm_pkg::FIELD_W-1:0] move_offset;
  logic [olm_pkg::FIELD_W-1:0]       slot_index;

  modport source (output valid, opcode, entry_number, move_offset, slot_index,
                  input ready);
  modport sink (input valid, opcode, entry_number, move_offset, slot_index,
                output ready);
endinterface

// ----- design/olm_rsp_if.sv -----
// Response channel: one result per command.
`timescale 1ns / 1ps

interface olm_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [olm_pkg::FIELD_W-1:0] result_entry;
  logic [olm_pkg::FIELD_W-1:0] result_slot;
  logic [1:0]                  status;

  modport source (output valid, result_entry, result_slot, status, input ready);
  modport sink (input valid, result_entry, result_slot, status, output ready);
endinterface

// ----- design/olm_cfg_if.sv -----
// Configuration write channel for entry_count.
`timescale 1ns / 1ps

interface olm_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [olm_pkg::FIELD_W-1:0] entry_count;

  modport source (output valid, entry_count, input ready);
  modport sink (input valid, entry_count, output ready);
endinterface

// ----- design/olm_table.sv -----
// 64-entry table with per-entry valid bits; an unwritten entry reads as its own index.
`timescale 1ns / 1ps

module olm_table (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          clear,
  input  olm_pkg::tbl_req_t             req,
  output logic [olm_pkg::IDX_W-1:0]     rdata
);

  logic [olm_pkg::IDX_W-1:0]       mem [olm_pkg::MAX_ENTRIES];
  logic [olm_pkg::MAX_ENTRIES-1:0] vld;
  logic [olm_pkg::IDX_W-1:0]       rd_data;
  logic [olm_pkg::IDX_W-1:0]       rd_addr;
  logic                            rd_vld;

  // Storage write and registered read
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd_data <= mem[req.raddr];
    rd_addr <= req.raddr;
  end

  // Valid bits: reset and clear restore the identity order at once
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (req.we) begin
        vld[req.waddr] <= 1'b1;
      end
      rd_vld <= vld[req.raddr];
    end
  end

  assign rdata = rd_vld ? rd_data : rd_addr;

endmodule

// ----- design/olm_seq.sv -----
// Sequencer: decodes a command and walks the shift one slot per step.
`timescale 1ns / 1ps

module olm_seq (
  input  logic                          clk,
  input  logic                          rst,
  olm_cmd_if.sink                       cmd,
  input  logic [olm_pkg::FIELD_W-1:0]   count,
  input  logic [olm_pkg::IDX_W-1:0]     eas_rdata,
  input  logic [olm_pkg::IDX_W-1:0]     soe_rdata,
  input  logic                          res_ready,
  output olm_pkg::tbl_req_t             eas_req,
  output olm_pkg::tbl_req_t             soe_req,
  output olm_pkg::res_t                 res,
  output logic                          res_valid,
  output logic                          idle
);

  olm_pkg::state_t                 state, state_next;
  olm_pkg::opcode_t                op;
  logic [olm_pkg::FIELD_W-1:0]     ent;
  logic [olm_pkg::FIELD_W-1:0]     off;
  logic [olm_pkg::FIELD_W-1:0]     slot;
  logic [olm_pkg::IDX_W-1:0]       j, j_next;
  logic [olm_pkg::IDX_W-1:0]       tgt, tgt_next;
  logic                            dir_up, dir_up_next;
  olm_pkg::status_t                stat, stat_next;
  olm_pkg::res_t                   res_next;

  logic [olm_pkg::FIELD_W-1:0]     ent_m1, slot_m1, last;
  logic [olm_pkg::IDX_W-1:0]       last_idx, cur_c, tgt_c, j_step;
  logic signed [olm_pkg::FIELD_W:0] tgt_sum;
  logic                            move_err, read_err, tgt_low, tgt_high;

  assign idle      = (state == olm_pkg::S_IDLE);
  assign cmd.ready = idle;
  assign res_valid = (state == olm_pkg::S_OUT);

  // Range checks against the list size
  assign ent_m1   = ent - olm_pkg::FIELD_W'(1);
  assign slot_m1  = slot - olm_pkg::FIELD_W'(1);
  assign last     = count - olm_pkg::FIELD_W'(1);
  assign last_idx = last[olm_pkg::IDX_W-1:0];
  assign move_err = (ent == '0) || (ent > count);
  assign read_err = (slot == '0) || (slot > count);

  // Target slot: current slot plus signed offset, clamped to the list ends
  assign cur_c    = (olm_pkg::FIELD_W'(soe_rdata) >= count) ? last_idx : soe_rdata;
  assign tgt_sum  = $signed((olm_pkg::FIELD_W+1)'(cur_c))
                  + $signed({off[olm_pkg::FIELD_W-1], off});
  assign tgt_low  = (tgt_sum < 0);
  assign tgt_high = (tgt_sum > $signed({1'b0, last}));
  assign tgt_c    = tgt_low  ? '0 :
                    tgt_high ? last_idx : tgt_sum[olm_pkg::IDX_W-1:0];

  // Shared step unit for the shift walk
  assign j_step = dir_up ? j + olm_pkg::IDX_W'(1) : j - olm_pkg::IDX_W'(1);

  // State register and command capture
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= olm_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      op   <= olm_pkg::opcode_t'(cmd.opcode);
      ent  <= cmd.entry_number;
      off  <= cmd.move_offset;
      slot <= cmd.slot_index;
    end
    j      <= j_next;
    tgt    <= tgt_next;
    dir_up <= dir_up_next;
    stat   <= stat_next;
    res    <= res_next;
  end

  // Next state, table accesses and result
  always_comb begin
    state_next  = state;
    j_next      = j;
    tgt_next    = tgt;
    dir_up_next = dir_up;
    stat_next   = stat;
    res_next    = res;
    eas_req     = '0;
    soe_req     = '0;
    case (state)
      olm_pkg::S_IDLE: begin
        if (cmd.valid) begin
          state_next = olm_pkg::S_LOOKUP;
        end
      end
      olm_pkg::S_LOOKUP: begin
        eas_req.raddr = slot_m1[olm_pkg::IDX_W-1:0];
        soe_req.raddr = ent_m1[olm_pkg::IDX_W-1:0];
        if ((op == olm_pkg::OP_READ) ? read_err : move_err) begin
          res_next.entry  = '0;
          res_next.slot   = '0;
          res_next.status = olm_pkg::ST_RANGE;
          state_next      = olm_pkg::S_OUT;
        end else begin
          state_next = olm_pkg::S_FETCH;
        end
      end
      olm_pkg::S_FETCH: begin
        if (op == olm_pkg::OP_READ) begin
          res_next.entry  = olm_pkg::FIELD_W'(eas_rdata) + olm_pkg::FIELD_W'(1);
          res_next.slot   = slot;
          res_next.status = olm_pkg::ST_OK;
          state_next      = olm_pkg::S_OUT;
        end else begin
          j_next      = cur_c;
          tgt_next    = tgt_c;
          dir_up_next = (tgt_c > cur_c);
          stat_next   = (tgt_low || tgt_high) ? olm_pkg::ST_CLAMP : olm_pkg::ST_OK;
          state_next  = (tgt_c == cur_c) ? olm_pkg::S_PLACE : olm_pkg::S_SHIFT_RD;
        end
      end
      olm_pkg::S_SHIFT_RD: begin
        // fetch the neighbor that slides into slot j
        eas_req.raddr = j_step;
        state_next    = olm_pkg::S_SHIFT_WR;
      end
      olm_pkg::S_SHIFT_WR: begin
        eas_req.we    = 1'b1;
        eas_req.waddr = j;
        eas_req.wdata = eas_rdata;
        soe_req.we    = 1'b1;
        soe_req.waddr = eas_rdata;
        soe_req.wdata = j;
        j_next        = j_step;
        state_next    = (j_step == tgt) ? olm_pkg::S_PLACE : olm_pkg::S_SHIFT_RD;
      end
      olm_pkg::S_PLACE: begin
        eas_req.we      = 1'b1;
        eas_req.waddr   = tgt;
        eas_req.wdata   = ent_m1[olm_pkg::IDX_W-1:0];
        soe_req.we      = 1'b1;
        soe_req.waddr   = ent_m1[olm_pkg::IDX_W-1:0];
        soe_req.wdata   = tgt;
        res_next.entry  = ent;
        res_next.slot   = olm_pkg::FIELD_W'(tgt) + olm_pkg::FIELD_W'(1);
        res_next.status = stat;
        state_next      = olm_pkg::S_OUT;
      end
      olm_pkg::S_OUT: begin
        if (res_ready) begin
          state_next = olm_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = olm_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ----- design/ordered_list_move_by_offset_unit.sv -----
// Top level: ordered list with move-by-offset and read-by-slot.
`timescale 1ns / 1ps

// Keeps a list of entry_count entries as a slot-to-entry table and its inverse,
// both starting in identity order. A move takes the named entry to its slot plus
// a signed offset (clamped to the list ends, status 1), sliding the entries in
// between by one place; a read returns the entry at a slot. Out-of-range numbers
// give status 2 with zero result fields. One command is in work at a time: a
// read passes through the lookup, fetch and output states, a range error skips
// the fetch, and a move walks a read state and a write state on the slot-to-entry
// table for each sliding entry before it places the named entry. The finished
// result sits in an output register, so the next command is taken while it
// waits. A write to entry_count (taken only while idle) restores identity order
// at once through per-entry valid bits; there is no clearing pass after reset.
module ordered_list_move_by_offset_unit (
  input  logic    clk,
  input  logic    rst,
  olm_cmd_if.sink cmd,
  olm_rsp_if.source rsp,
  olm_cfg_if.sink cfg
);

  logic [olm_pkg::FIELD_W-1:0] count, count_next;
  logic                        cfg_wr, idle, res_valid, res_ready;
  olm_pkg::tbl_req_t           eas_req, soe_req;
  logic [olm_pkg::IDX_W-1:0]   eas_rdata, soe_rdata;
  olm_pkg::res_t               res;

  // entry_count register, clamped to 1..MAX_ENTRIES
  assign cfg.ready = idle;
  assign cfg_wr    = cfg.valid && cfg.ready;

  always_comb begin
    if (cfg.entry_count == '0) begin
      count_next = olm_pkg::FIELD_W'(1);
    end else if (cfg.entry_count > olm_pkg::FIELD_W'(olm_pkg::MAX_ENTRIES)) begin
      count_next = olm_pkg::FIELD_W'(olm_pkg::MAX_ENTRIES);
    end else begin
      count_next = cfg.entry_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= olm_pkg::COUNT_RESET;
    end else if (cfg_wr) begin
      count <= count_next;
    end
  end

  // Slot-to-entry and entry-to-slot tables
  olm_table u_eas (
    .clk   (clk),
    .rst   (rst),
    .clear (cfg_wr),
    .req   (eas_req),
    .rdata (eas_rdata)
  );

  olm_table u_soe (
    .clk   (clk),
    .rst   (rst),
    .clear (cfg_wr),
    .req   (soe_req),
    .rdata (soe_rdata)
  );

  olm_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .count     (count),
    .eas_rdata (eas_rdata),
    .soe_rdata (soe_rdata),
    .res_ready (res_ready),
    .eas_req   (eas_req),
    .soe_req   (soe_req),
    .res       (res),
    .res_valid (res_valid),
    .idle      (idle)
  );

  // Output register: loads when empty or being drained
  assign res_ready = res_valid && (!rsp.valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (res_ready) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready) begin
      rsp.result_entry <= res.entry;
      rsp.result_slot  <= res.slot;
      rsp.status       <= res.status;
    end
  end

`ifndef SYNTHESIS
  // A command transfer always takes the unit busy on the next cycle
  a_busy_after_cmd: assert property (@(posedge clk) disable iff (rst)
    (cmd.valid && cmd.ready) |=> !cmd.ready)
    else $error("command accepted while previous one still in work");

  // Range errors and only range errors carry a zero entry
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> ((rsp.status == olm_pkg::ST_RANGE) == (rsp.result_entry == '0)))
    else $error("result entry inconsistent with status");

  // A good result names a slot inside the list
  a_slot_in_list: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && (rsp.status != olm_pkg::ST_RANGE))
      |-> ((rsp.result_slot != '0) && (rsp.result_slot <= count)))
    else $error("result slot outside the list");
`endif

endmodule

// ----- dv/tb_ordered_list_move_by_offset_unit.sv -----
// Self-checking testbench for the ordered list move-by-offset unit.
`timescale 1ns / 1ps

module tb_ordered_list_move_by_offset_unit;

  localparam int  PHASES      = 12;
  localparam int  PHASE_ITEMS = 138;
  localparam int  DRAIN_TAIL  = 150;
  localparam longint LIMIT    = 2000000;

  // One row of the directed table: either an entry_count write or a command
  typedef struct {
    bit                                 is_cfg;
    logic [olm_pkg::FIELD_W-1:0]        cfg_val;
    olm_pkg::opcode_t                   op;
    logic [olm_pkg::FIELD_W-1:0]        en;
    logic signed [olm_pkg::FIELD_W-1:0] off;
    logic [olm_pkg::FIELD_W-1:0]        si;
    bit                                 typed;
    olm_pkg::res_t                      want;
  } dir_row_t;

  logic clk;
  logic rst;

  olm_cmd_if cmd_ch ();
  olm_rsp_if rsp_ch ();
  olm_cfg_if cfg_ch ();

  ordered_list_move_by_offset_unit uut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  // Predicted list state
  logic [olm_pkg::IDX_W-1:0] entry_by_slot [olm_pkg::MAX_ENTRIES];
  logic [olm_pkg::IDX_W-1:0] slot_by_entry [olm_pkg::MAX_ENTRIES];
  int                        list_len;

  olm_pkg::res_t pending_results [$];
  int            outstanding;
  int            mismatches;
  longint        cycle_count;

  // Typed expectation travelling with the command currently offered
  bit            row_typed;
  olm_pkg::res_t row_want;

  // Sender burst state and receiver stall state
  int burst_left;
  int stall_mode;
  int stall_left;

  dir_row_t dir_rows [$];

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Writing entry_count clamps it to 1..MAX_ENTRIES and restores identity order
  function automatic void load_list_len(logic [olm_pkg::FIELD_W-1:0] val);
    int n;
    n = int'(val);
    if (n < 1) n = 1;
    if (n > olm_pkg::MAX_ENTRIES) n = olm_pkg::MAX_ENTRIES;
    list_len = n;
    for (int i = 0; i < olm_pkg::MAX_ENTRIES; i++) begin
      entry_by_slot[i] = olm_pkg::IDX_W'(i);
      slot_by_entry[i] = olm_pkg::IDX_W'(i);
    end
  endfunction

  // Apply one command to the predicted list and return its result
  function automatic olm_pkg::res_t apply_command(olm_pkg::opcode_t op,
                                                  logic [olm_pkg::FIELD_W-1:0] en,
                                                  logic signed [olm_pkg::FIELD_W-1:0] off,
                                                  logic [olm_pkg::FIELD_W-1:0] si);
    olm_pkg::res_t r;
    int            cur, tgt, e;
    r        = '0;
    r.status = olm_pkg::ST_OK;
    if (op == olm_pkg::OP_READ) begin
      if (si < 1 || int'(si) > list_len) begin
        r.status = olm_pkg::ST_RANGE;
        return r;
      end
      r.entry = olm_pkg::FIELD_W'(entry_by_slot[si - 1]) + olm_pkg::FIELD_W'(1);
      r.slot  = si;
      return r;
    end
    if (en < 1 || int'(en) > list_len) begin
      r.status = olm_pkg::ST_RANGE;
      return r;
    end
    e   = int'(en) - 1;
    cur = int'(slot_by_entry[e]);
    if (cur >= list_len) cur = list_len - 1;
    tgt = cur + int'(off);
    if (tgt < 0) begin
      tgt      = 0;
      r.status = olm_pkg::ST_CLAMP;
    end else if (tgt > list_len - 1) begin
      tgt      = list_len - 1;
      r.status = olm_pkg::ST_CLAMP;
    end
    // slide the entries in between one place toward the vacated slot
    if (tgt < cur) begin
      for (int j = cur; j > tgt; j--) begin
        entry_by_slot[j] = entry_by_slot[j - 1];
        slot_by_entry[entry_by_slot[j]] = olm_pkg::IDX_W'(j);
      end
    end else if (tgt > cur) begin
      for (int j = cur; j < tgt; j++) begin
        entry_by_slot[j] = entry_by_slot[j + 1];
        slot_by_entry[entry_by_slot[j]] = olm_pkg::IDX_W'(j);
      end
    end
    entry_by_slot[tgt] = olm_pkg::IDX_W'(e);
    slot_by_entry[e]   = olm_pkg::IDX_W'(tgt);
    r.entry = en;
    r.slot  = olm_pkg::FIELD_W'(tgt + 1);
    return r;
  endfunction

  function automatic dir_row_t cmd_row(olm_pkg::opcode_t op, int en, int off, int si,
                                       bit typed, int e, int s, olm_pkg::status_t st);
    dir_row_t row;
    row.is_cfg      = 1'b0;
    row.cfg_val     = '0;
    row.op          = op;
    row.en          = olm_pkg::FIELD_W'(en);
    row.off         = olm_pkg::FIELD_W'(off);
    row.si          = olm_pkg::FIELD_W'(si);
    row.typed       = typed;
    row.want.entry  = olm_pkg::FIELD_W'(e);
    row.want.slot   = olm_pkg::FIELD_W'(s);
    row.want.status = st;
    return row;
  endfunction

  function automatic dir_row_t cfg_row(int val);
    dir_row_t row;
    row         = cmd_row(olm_pkg::OP_READ, 0, 0, 0, 1'b0, 0, 0, olm_pkg::ST_OK);
    row.is_cfg  = 1'b1;
    row.cfg_val = olm_pkg::FIELD_W'(val);
    return row;
  endfunction

  // Append one row to the directed table
  function automatic void add_row(dir_row_t row);
    dir_rows = {dir_rows, row};
  endfunction

  task automatic report_mismatch(string what);
    $display("ERROR cycle %0d: %s", cycle_count, what);
    mismatches++;
  endtask

  // Hold the command channel until every expected result has come
  task automatic wait_drain();
    cmd_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_count(logic [olm_pkg::FIELD_W-1:0] val, output int eff_len);
    wait_drain();
    cfg_ch.valid       <= 1'b1;
    cfg_ch.entry_count <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    eff_len = (val < 1) ? 1 :
              (int'(val) > olm_pkg::MAX_ENTRIES ? olm_pkg::MAX_ENTRIES : int'(val));
  endtask

  // Offer one command, with a random gap between bursts, and wait for its transfer
  task automatic send_cmd(olm_pkg::opcode_t op, logic [olm_pkg::FIELD_W-1:0] en,
                          logic signed [olm_pkg::FIELD_W-1:0] off,
                          logic [olm_pkg::FIELD_W-1:0] si, bit typed, olm_pkg::res_t want);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        cmd_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    cmd_ch.valid        <= 1'b1;
    cmd_ch.opcode       <= op;
    cmd_ch.entry_number <= en;
    cmd_ch.move_offset  <= off;
    cmd_ch.slot_index   <= si;
    row_typed           <= typed;
    row_want            <= want;
    do @(posedge clk); while (!cmd_ch.ready);
  endtask

  // Receiver: ready pattern picks a new random mode whenever its stall counter runs out
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(50, 400);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: rsp_ch.ready <= 1'b1;
      1: rsp_ch.ready <= 1'($urandom_range(0, 1));
      2: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
      default: rsp_ch.ready <= ((cycle_count % 8) > 2);
    endcase
  end

  // Cycle count and run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("FAIL ordered_list_move_by_offset_unit");
      $finish;
    end
  end

  // Transfers: config updates the predictor, commands queue a result, responses are checked
  always @(posedge clk) begin : monitor
    olm_pkg::res_t want;
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("response with nothing expected: entry %0d slot %0d st %0d",
                                    rsp_ch.result_entry, rsp_ch.result_slot, rsp_ch.status));
        end else begin
          want = pending_results.pop_front();
          if (rsp_ch.result_entry !== want.entry)
            report_mismatch($sformatf("result_entry got %0d expected %0d",
                                      rsp_ch.result_entry, want.entry));
          if (rsp_ch.result_slot !== want.slot)
            report_mismatch($sformatf("result_slot got %0d expected %0d",
                                      rsp_ch.result_slot, want.slot));
          if (rsp_ch.status !== want.status)
            report_mismatch($sformatf("status got %0d expected %0d",
                                      rsp_ch.status, want.status));
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) load_list_len(cfg_ch.entry_count);
      if (cmd_ch.valid && cmd_ch.ready) begin
        want = apply_command(olm_pkg::opcode_t'(cmd_ch.opcode), cmd_ch.entry_number,
                             cmd_ch.move_offset, cmd_ch.slot_index);
        if (row_typed) want = row_want;
        pending_results = {pending_results, want};
      end
      outstanding <= pending_results.size();
    end
  end

  // Stimulus
  initial begin
    int                                 cur_len;
    int                                 cval;
    olm_pkg::opcode_t                   op;
    logic [olm_pkg::FIELD_W-1:0]        en, si;
    logic signed [olm_pkg::FIELD_W-1:0] off;
    olm_pkg::res_t                      none;

    clk                 = 1'b0;
    rst                 = 1'b1;
    cmd_ch.valid        = 1'b0;
    cmd_ch.opcode       = olm_pkg::OP_MOVE;
    cmd_ch.entry_number = '0;
    cmd_ch.move_offset  = '0;
    cmd_ch.slot_index   = '0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.entry_count  = '0;
    rsp_ch.ready        = 1'b0;
    row_typed           = 1'b0;
    row_want            = '0;
    none                = '0;
    outstanding         = 0;
    mismatches          = 0;
    cycle_count         = 0;
    burst_left          = 0;
    stall_mode          = 0;
    stall_left          = 0;
    cur_len             = int'(olm_pkg::COUNT_RESET);
    load_list_len(olm_pkg::COUNT_RESET);

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: range limits, clamps at both ends, zero offset, single entry
    add_row(cmd_row(olm_pkg::OP_READ, 0, 0, 1, 1, 1, 1, olm_pkg::ST_OK));
    add_row(cmd_row(olm_pkg::OP_READ, 0, 0, 64, 1, 64, 64, olm_pkg::ST_OK));
    add_row(cmd_row(olm_pkg::OP_READ, 0, 0, 0, 1, 0, 0, olm_pkg::ST_RANGE));
    add_row(cmd_row(olm_pkg::OP_READ, 127, -64, 127, 1, 0, 0, olm_pkg::ST_RANGE));
    add_row(cmd_row(olm_pkg::OP_READ, 0, 0, 65, 1, 0, 0, olm_pkg::ST_RANGE));
    add_row(cmd_row(olm_pkg::OP_MOVE, 0, 1, 0, 1, 0, 0, olm_pkg::ST_RANGE));
    add_row(cmd_row(olm_pkg::OP_MOVE, 127, 63, 127, 1, 0, 0, olm_pkg::ST_RANGE));
    add_row(cmd_row(olm_pkg::OP_MOVE, 1, 0, 0, 1, 1, 1, olm_pkg::ST_OK));
    add_row(cmd_row(olm_pkg::OP_MOVE, 1, -1, 0, 1, 1, 1, olm_pkg::ST_CLAMP));
    add_row(cmd_row(olm_pkg::OP_MOVE, 64, 1, 0, 1, 64, 64, olm_pkg::ST_CLAMP));
    add_row(cmd_row(olm_pkg::OP_MOVE, 1, 63, 0, 1, 1, 64, olm_pkg::ST_OK));
    add_row(cmd_row(olm_pkg::OP_READ, 0, 0, 64, 1, 1, 64, olm_pkg::ST_OK));
    add_row(cmd_row(olm_pkg::OP_READ, 0, 0, 1, 1, 2, 1, olm_pkg::ST_OK));
    add_row(cmd_row(olm_pkg::OP_MOVE, 1, -63, 0, 1, 1, 1, olm_pkg::ST_OK));
    add_row(cmd_row(olm_pkg::OP_MOVE, 5, -64, 0, 1, 5, 1, olm_pkg::ST_CLAMP));
    add_row(cmd_row(olm_pkg::OP_MOVE, 10, 20, 0, 0, 0, 0, olm_pkg::ST_OK));
    add_row(cmd_row(olm_pkg::OP_READ, 0, 0, 30, 0, 0, 0, olm_pkg::ST_OK));
    add_row(cfg_row(0));
    add_row(cmd_row(olm_pkg::OP_MOVE, 1, 5, 0, 1, 1, 1, olm_pkg::ST_CLAMP));
    add_row(cmd_row(olm_pkg::OP_MOVE, 2, 0, 0, 1, 0, 0, olm_pkg::ST_RANGE));
    add_row(cmd_row(olm_pkg::OP_READ, 0, 0, 2, 1, 0, 0, olm_pkg::ST_RANGE));
    add_row(cmd_row(olm_pkg::OP_READ, 0, 0, 1, 1, 1, 1, olm_pkg::ST_OK));
    add_row(cfg_row(127));
    add_row(cmd_row(olm_pkg::OP_READ, 0, 0, 64, 1, 64, 64, olm_pkg::ST_OK));
    add_row(cmd_row(olm_pkg::OP_MOVE, 64, -63, 0, 1, 64, 1, olm_pkg::ST_OK));
    add_row(cfg_row(2));
    add_row(cmd_row(olm_pkg::OP_MOVE, 1, 1, 0, 1, 1, 2, olm_pkg::ST_OK));
    add_row(cmd_row(olm_pkg::OP_READ, 0, 0, 1, 1, 2, 1, olm_pkg::ST_OK));

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg)
        write_count(dir_rows[i].cfg_val, cur_len);
      else
        send_cmd(dir_rows[i].op, dir_rows[i].en, dir_rows[i].off, dir_rows[i].si,
                 dir_rows[i].typed, dir_rows[i].want);
    end

    // Random phases, each under its own entry_count
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: cval = 64;
        1: cval = 1;
        2: cval = 2;
        3: cval = 127;
        4: cval = 0;
        5: cval = 3;
        default: cval = $urandom_range(0, 127);
      endcase
      write_count(olm_pkg::FIELD_W'(cval), cur_len);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k == PHASE_ITEMS / 2 && (ph % 3) == 1) wait_drain();
        op = olm_pkg::opcode_t'($urandom_range(0, 1));
        en = olm_pkg::FIELD_W'($urandom_range(1, cur_len));
        si = olm_pkg::FIELD_W'($urandom_range(1, cur_len));
        case ($urandom_range(0, 3))
          0: off = olm_pkg::FIELD_W'(int'($urandom_range(0, 6)) - 3);
          1: off = olm_pkg::FIELD_W'($urandom);
          2: off = olm_pkg::FIELD_W'(int'($urandom_range(0, cur_len)));
          default: off = olm_pkg::FIELD_W'(-int'($urandom_range(0, cur_len)));
        endcase
        // noise: numbers anywhere in the field
        if ($urandom_range(0, 99) < 12) begin
          en = olm_pkg::FIELD_W'($urandom);
          si = olm_pkg::FIELD_W'($urandom);
        end
        send_cmd(op, en, off, si, 1'b0, none);
      end
    end

    wait_drain();
    repeat (DRAIN_TAIL) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS ordered_list_move_by_offset_unit");
    end else begin
      $display("FAIL ordered_list_move_by_offset_unit");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/olm_pkg.sv
design/olm_cmd_if.sv
design/olm_rsp_if.sv
design/olm_cfg_if.sv
design/olm_table.sv
design/olm_seq.sv
design/ordered_list_move_by_offset_unit.sv
dv/tb_ordered_list_move_by_offset_unit.sv
